[hw/rtl/crc16fa_pkg.sv]
// Package for the CRC-16 frame appender: shared types, trailer constants,
// the byte-wise CRC fold and the trailer byte escape. No dependencies.
`default_nettype none

package crc16fa_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  CR_BYTE  = 8'h0D;
    localparam logic [7:0]  ESC_PAREN = 8'h28;
    localparam logic [7:0]  ESC_CR    = 8'h0D;
    localparam logic [7:0]  ESC_LF    = 8'h0A;

    typedef struct packed {
        logic fold_en;
        logic clear;
    } t_crc_ctl;

    // MSB-first fold of one byte into the CRC, eight shift steps
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] escape_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b == ESC_PAREN || b == ESC_CR || b == ESC_LF) begin
            r = b + 8'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/crc16fa_crc_unit.sv]
// Running CRC-16 register with its byte fold.
// Depends on crc16fa_pkg (t_crc_ctl, crc_fold).
`default_nettype none

module crc16fa_crc_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire crc16fa_pkg::t_crc_ctl i_ctl,
    input  wire logic [7:0]            i_data_byte,
    output logic [15:0]                o_crc_next
);

    logic [15:0] r_crc;

    assign o_crc_next = crc16fa_pkg::crc_fold(r_crc, i_data_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 16'h0000;
        end else if (i_ctl.fold_en) begin
            r_crc <= i_ctl.clear ? 16'h0000 : o_crc_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/crc16fa_out_stage.sv]
// Output register and trailer sequencer: passes body bytes, then CRC high,
// CRC low and CR. Depends on crc16fa_pkg (constants, escape_byte).
`default_nettype none

module crc16fa_out_stage (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    input  wire logic [15:0] i_crc_next,
    input  wire logic        i_stall,
    output logic             o_take,
    output logic             o_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);

    typedef enum logic [1:0] {
        PH_BODY,
        PH_HI,
        PH_LO,
        PH_CR
    } t_phase;

    t_phase      r_phase;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [15:0] r_trail;
    logic        out_free;

    assign out_free   = !r_out_valid || !i_stall;
    assign o_take     = out_free && (r_phase == PH_BODY) && i_in_valid;
    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_BODY;
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            case (r_phase)
                PH_BODY: begin
                    r_out_valid <= i_in_valid;
                    if (i_in_valid) begin
                        r_out_byte <= i_in_byte;
                        r_out_last <= 1'b0;
                        if (i_in_last) begin
                            r_phase <= PH_HI;
                            r_trail <= i_crc_next;
                        end
                    end
                end
                PH_HI: begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= crc16fa_pkg::escape_byte(r_trail[15:8]);
                    r_out_last  <= 1'b0;
                    r_phase     <= PH_LO;
                end
                PH_LO: begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= crc16fa_pkg::escape_byte(r_trail[7:0]);
                    r_out_last  <= 1'b0;
                    r_phase     <= PH_CR;
                end
                PH_CR: begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= crc16fa_pkg::CR_BYTE;
                    r_out_last  <= 1'b1;
                    r_phase     <= PH_BODY;
                end
                default: begin
                    r_phase <= PH_BODY;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/crc16_frame_appender.sv]
// Top level of the CRC-16 frame appender.
// Depends on crc16fa_pkg, crc16fa_crc_unit and crc16fa_out_stage.
//
// Body bytes are taken one per cycle when neither i_stall nor the trailer holds
// them, and are passed through unchanged while a CRC-16/XMODEM (poly 0x1021,
// init 0, MSB first) runs over them. The byte flagged last is followed by three
// trailer bytes: CRC high, CRC low (each bumped by one if it is 0x28, 0x0D or
// 0x0A) and CR 0x0D with o_out_last set; the CRC then restarts at zero. The
// trailer bytes come from the single output register; while they are sent,
// o_stall holds input transfers. Each byte passes through the input register
// and then the output register.
`default_nettype none

module crc16_frame_appender (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    logic                  take;
    logic [15:0]           crc_next;
    crc16fa_pkg::t_crc_ctl crc_ctl;

    assign o_stall         = r_in_valid && !take;
    assign crc_ctl.fold_en = take;
    assign crc_ctl.clear   = r_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
            if (i_valid) begin
                r_in_byte <= i_data_byte;
                r_in_last <= i_last_byte;
            end
        end
    end

    crc16fa_crc_unit u_crc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (crc_ctl),
        .i_data_byte (r_in_byte),
        .o_crc_next  (crc_next)
    );

    crc16fa_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (r_in_valid),
        .i_in_byte  (r_in_byte),
        .i_in_last  (r_in_last),
        .i_crc_next (crc_next),
        .i_stall    (i_stall),
        .o_take     (take),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

endmodule

`default_nettype wire

[hw/rtl/crc16fa_checker.sv]
// Port-level checks for crc16_frame_appender, attached with bind.
// Depends on crc16fa_pkg (CR_BYTE).
`default_nettype none

module crc16fa_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_stall,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_out_last
);

    // frame end marker is always the carriage return
    a_last_is_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_last |-> o_out_byte == crc16fa_pkg::CR_BYTE)
        else $error("out_last without CR byte");

    // input may only be held off while output holds a transfer
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_out_last))
        else $error("stalled output changed");

endmodule

bind crc16_frame_appender crc16fa_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_stall    (i_stall),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .o_out_byte (o_out_byte),
    .o_out_last (o_out_last)
);

`default_nettype wire

[verif/crc16fa_checker.sv]
// Scoreboard for the CRC-16 frame appender: watches both channels, predicts the
// passed-through bytes and the CRC trailer, and compares every output transfer.
// Depends on crc16fa_pkg for the trailer and escape constants.
`timescale 1ns / 100ps

module crc16fa_scoreboard (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [7:0] i_out_byte,
    input  wire logic       i_out_last,
    output int              o_fail_count,
    output int              o_pending
);

    typedef struct packed {
        logic [7:0] b_val;
        logic       last;
    } t_frame_byte;

    t_frame_byte expected_bytes[$];
    logic [15:0] frame_crc = 16'h0000;
    int          fails     = 0;

    // bitwise MSB-first CRC-16/XMODEM update
    function automatic logic [15:0] xmodem_fold(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ d[k];
            r = {r[14:0], 1'b0} ^ (fb ? crc16fa_pkg::CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic logic [7:0] escape_trailer(input logic [7:0] b);
        case (b)
            crc16fa_pkg::ESC_PAREN,
            crc16fa_pkg::ESC_CR,
            crc16fa_pkg::ESC_LF: return b + 8'd1;
            default:             return b;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_frame_byte exp_b;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected transfer: expected none, actual byte %02h last %0b",
                             $time, i_out_byte, i_out_last);
                    fails++;
                end else begin
                    exp_b = expected_bytes.pop_front();
                    if (i_out_byte !== exp_b.b_val) begin
                        $display("%0t: out_byte mismatch: expected %02h actual %02h",
                                 $time, exp_b.b_val, i_out_byte);
                        fails++;
                    end
                    if (i_out_last !== exp_b.last) begin
                        $display("%0t: out_last mismatch: expected %0b actual %0b",
                                 $time, exp_b.last, i_out_last);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                frame_crc = xmodem_fold(frame_crc, i_data_byte);
                expected_bytes.push_back('{b_val: i_data_byte, last: 1'b0});
                if (i_last_byte) begin
                    expected_bytes.push_back(
                        '{b_val: escape_trailer(frame_crc[15:8]), last: 1'b0});
                    expected_bytes.push_back(
                        '{b_val: escape_trailer(frame_crc[7:0]), last: 1'b0});
                    expected_bytes.push_back(
                        '{b_val: crc16fa_pkg::CR_BYTE, last: 1'b1});
                    frame_crc = 16'h0000;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_bytes.size();
    end

endmodule

[verif/tb.sv]
// Top of the CRC-16 frame appender testbench: clock, reset, framed byte stimulus
// with bursty sender and patterned receiver stalls, and the final verdict.
// Depends on crc16fa_pkg, crc16_frame_appender and crc16fa_scoreboard.
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_ITEMS = 480;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    int         fail_count;
    int         pending;

    int burst_left  = 1;
    bit valid_hi    = 1'b0;
    int items_sent  = 0;
    int stall_cycle = 0;
    int stall_mode  = 0;

    crc16_frame_appender dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

    crc16fa_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_byte   (o_out_byte),
        .i_out_last   (o_out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver stall pattern in one of four randomly picked modes
    always @(posedge i_clk) begin
        stall_cycle++;
        if (stall_cycle % 64 == 0) begin
            stall_mode = $urandom_range(3);
        end
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(99) < 20);
            2:       i_stall <= ($urandom_range(99) < 65);
            default: i_stall <= (stall_cycle % 7 < 3);
        endcase
    end

    // one transfer on the input channel, then a random gap at the end of a burst
    task automatic put_byte(input logic [7:0] d, input logic l);
        int gap;
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= l;
        valid_hi    = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(20, 1);
            gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                i_valid  <= 1'b0;
                valid_hi = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return ($urandom_range(1) == 0) ? crc16fa_pkg::ESC_PAREN
                                                     : crc16fa_pkg::ESC_LF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        int flen;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-byte frames at the byte extremes
        put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b1);
        // CRC low byte lands on 0x28, 0x0D, 0x0A
        put_byte(8'h2A, 1'b1);
        put_byte(8'hA7, 1'b1);
        put_byte(8'h4E, 1'b1);
        // CRC high byte lands on 0x28, 0x0D, 0x0A
        put_byte(8'h46, 1'b1);
        put_byte(8'h01, 1'b0);
        put_byte(8'h74, 1'b1);
        put_byte(8'h02, 1'b0);
        put_byte(8'h60, 1'b1);
        // multi-byte frame around the sign bit
        put_byte(8'h80, 1'b0);
        put_byte(8'h7F, 1'b0);
        put_byte(8'h55, 1'b0);
        put_byte(8'hAA, 1'b1);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            flen = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            for (int n = 1; n <= flen; n++) begin
                put_byte(pick_byte(), n == flen);
            end
        end
        if (valid_hi) begin
            i_valid <= 1'b0;
        end

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
